FILE: sv/apwd_pkg.sv
// Package for the accelerometer pickup wake detector.
// Holds the configuration register indices, field widths, reset values and config struct.
// No dependencies.
`default_nettype none

package apwd_pkg;

	localparam int THRESH_W    = 16;
	localparam int VOTE_W      = 8;
	localparam int DELAY_W     = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [THRESH_W-1:0] WAKE_THRESHOLD_RST      = 16'd150;
	localparam logic [VOTE_W-1:0]   WAKE_VOTES_NEEDED_RST   = 8'd3;
	localparam logic [THRESH_W-1:0] SETTLE_THRESHOLD_RST    = 16'd60;
	localparam logic [VOTE_W-1:0]   SETTLE_VOTES_NEEDED_RST = 8'd3;
	localparam logic [DELAY_W-1:0]  BASELINE_DELAY_RST      = 16'd2000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WAKE_THRESHOLD      = 3'd0,
		REG_WAKE_VOTES_NEEDED   = 3'd1,
		REG_SETTLE_THRESHOLD    = 3'd2,
		REG_SETTLE_VOTES_NEEDED = 3'd3,
		REG_BASELINE_DELAY      = 3'd4
	} apwd_reg_t;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic [THRESH_W-1:0] wake_threshold;
		logic [VOTE_W-1:0]   wake_votes_needed;
		logic [THRESH_W-1:0] settle_threshold;
		logic [VOTE_W-1:0]   settle_votes_needed;
		logic [DELAY_W-1:0]  baseline_delay;
	} apwd_cfg_t;

endpackage

`default_nettype wire

FILE: sv/apwd_if.sv
// Channel interfaces of the pickup wake detector: input items, results, config writes.
// Depends on apwd_pkg for the config index and data widths.
`default_nettype none

interface apwd_item_if #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int TIME_WIDTH   = 48
);
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic signed [SAMPLE_WIDTH-1:0] accel_x;
	logic signed [SAMPLE_WIDTH-1:0] accel_y;
	logic signed [SAMPLE_WIDTH-1:0] accel_z;
	logic [TIME_WIDTH-1:0]          time_ms;

	modport source (output valid, op, accel_x, accel_y, accel_z, time_ms, input ready);
	modport sink   (input valid, op, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface apwd_result_if;
	logic valid;
	logic ready;
	logic picked_up;
	logic armed;

	modport source (output valid, picked_up, armed, input ready);
	modport sink   (input valid, picked_up, armed, output ready);
endinterface

interface apwd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [apwd_pkg::CFG_INDEX_W-1:0] index;
	logic [apwd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/accel_pickup_wake_detector_unit.sv
// Top level of the accelerometer pickup wake detector.
// Depends on apwd_pkg, the channel interfaces in apwd_if.sv, apwd_regs and apwd_core.
//
// Takes one item per clock cycle while results are taken, and gives exactly one result
// per item (picked_up, armed). An accepted item is held in an input register; when the
// result register can take it, the compare and state update run in one pass and the
// result is loaded into the output register, from which it is offered. The output register
// decouples the two sides: new items keep flowing while a result waits as long as that
// register can be emptied in the same cycle. A start item (op = 0)
// records the sleep time and disarms the block. Configuration writes are taken in any
// cycle and should be made only while no item is in flight; writes to indices above 4
// are dropped.
`default_nettype none

module accel_pickup_wake_detector_unit #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int TIME_WIDTH   = 48,
	parameter int COUNT_WIDTH  = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	apwd_item_if.sink      item,
	apwd_result_if.source  result,
	apwd_cfg_if.sink       cfg
);
	import apwd_pkg::*;

	apwd_cfg_t cfg_regs;

	logic                           valid_s1;
	logic                           op_s1;
	logic signed [SAMPLE_WIDTH-1:0] accel_x_s1, accel_y_s1, accel_z_s1;
	logic [TIME_WIDTH-1:0]          time_ms_s1;

	logic res_valid_q;
	logic picked_up_q;
	logic armed_q;

	logic advance;
	logic core_picked_up;
	logic core_armed;

	assign cfg.ready   = 1'b1;
	assign advance     = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready  = !valid_s1 || advance;

	apwd_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	apwd_core #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.TIME_WIDTH   (TIME_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.op        (op_s1),
		.accel_x   (accel_x_s1),
		.accel_y   (accel_y_s1),
		.accel_z   (accel_z_s1),
		.time_ms   (time_ms_s1),
		.cfg       (cfg_regs),
		.picked_up (core_picked_up),
		.armed     (core_armed)
	);

	// input register: load on every transfer, drop once the item has been processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1      <= item.op;
			accel_x_s1 <= item.accel_x;
			accel_y_s1 <= item.accel_y;
			accel_z_s1 <= item.accel_z;
			time_ms_s1 <= item.time_ms;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			picked_up_q <= core_picked_up;
			armed_q     <= core_armed;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.picked_up = picked_up_q;
	assign result.armed     = armed_q;

endmodule

`default_nettype wire

FILE: sv/apwd_regs.sv
// Configuration register file of the pickup wake detector.
// Depends on apwd_pkg for register indices, widths and reset values.
`default_nettype none

module apwd_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [apwd_pkg::CFG_INDEX_W-1:0] wr_index,
	input  wire logic [apwd_pkg::CFG_DATA_W-1:0]  wr_data,
	output apwd_pkg::apwd_cfg_t                   cfg
);
	import apwd_pkg::*;

	apwd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wake_threshold      <= WAKE_THRESHOLD_RST;
			cfg_q.wake_votes_needed   <= WAKE_VOTES_NEEDED_RST;
			cfg_q.settle_threshold    <= SETTLE_THRESHOLD_RST;
			cfg_q.settle_votes_needed <= SETTLE_VOTES_NEEDED_RST;
			cfg_q.baseline_delay      <= BASELINE_DELAY_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WAKE_THRESHOLD:      cfg_q.wake_threshold      <= wr_data[THRESH_W-1:0];
				REG_WAKE_VOTES_NEEDED:   cfg_q.wake_votes_needed   <= wr_data[VOTE_W-1:0];
				REG_SETTLE_THRESHOLD:    cfg_q.settle_threshold    <= wr_data[THRESH_W-1:0];
				REG_SETTLE_VOTES_NEEDED: cfg_q.settle_votes_needed <= wr_data[VOTE_W-1:0];
				REG_BASELINE_DELAY:      cfg_q.baseline_delay      <= wr_data[DELAY_W-1:0];
				default: ; // unmapped index: drop the write
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: sv/apwd_core.sv
// Detection state and single-pass update logic of the pickup wake detector.
// Depends on apwd_pkg for the config struct, widths and op codes.
`default_nettype none

module apwd_core #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int TIME_WIDTH   = 48,
	parameter int COUNT_WIDTH  = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           fire,
	input  wire logic                           op,
	input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x,
	input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y,
	input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z,
	input  wire logic [TIME_WIDTH-1:0]          time_ms,
	input  apwd_pkg::apwd_cfg_t                 cfg,
	output logic                                picked_up,
	output logic                                armed
);
	import apwd_pkg::*;

	localparam int DW   = ((SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W) + 2;
	localparam int CMPW = (COUNT_WIDTH > VOTE_W) ? COUNT_WIDTH : VOTE_W;

	function automatic logic beyond(input logic signed [SAMPLE_WIDTH-1:0] a,
			input logic signed [SAMPLE_WIDTH-1:0] b, input logic [THRESH_W-1:0] lim);
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] l;
		d = DW'(a) - DW'(b);
		l = DW'(lim);
		return (d > l) || (d < -l);
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// control state
	logic                    have_baseline_q;
	logic                    have_prev_q;
	logic                    last_time_valid_q;
	logic [COUNT_WIDTH-1:0]  still_count_q;
	logic [COUNT_WIDTH-1:0]  move_count_q;
	logic [TIME_WIDTH-1:0]   sleep_start_q;
	// payload state, guarded by the flags above
	logic [TIME_WIDTH-1:0]          last_time_q;
	logic signed [SAMPLE_WIDTH-1:0] base_x_q, base_y_q, base_z_q;
	logic signed [SAMPLE_WIDTH-1:0] prev_x_q, prev_y_q, prev_z_q;

	logic [TIME_WIDTH:0]    due_sum;
	logic [TIME_WIDTH-1:0]  due;
	logic                   newer;
	logic                   due_reached;
	logic                   settle_moved;
	logic                   wake_moved;
	logic [COUNT_WIDTH-1:0] still_next;
	logic [COUNT_WIDTH-1:0] move_next;
	logic                   capture;
	logic                   take_settle;
	logic                   take_wake;

	always_comb begin
		due_sum     = {1'b0, sleep_start_q} + (TIME_WIDTH+1)'(cfg.baseline_delay);
		due         = due_sum[TIME_WIDTH] ? '1 : due_sum[TIME_WIDTH-1:0];
		due_reached = (time_ms >= due);
		newer       = !(last_time_valid_q && (time_ms <= last_time_q));

		settle_moved = beyond(accel_x, prev_x_q, cfg.settle_threshold) ||
			beyond(accel_y, prev_y_q, cfg.settle_threshold) ||
			beyond(accel_z, prev_z_q, cfg.settle_threshold);
		wake_moved = beyond(accel_x, base_x_q, cfg.wake_threshold) ||
			beyond(accel_y, base_y_q, cfg.wake_threshold) ||
			beyond(accel_z, base_z_q, cfg.wake_threshold);

		// a fresh run starts at one after a jump or on the first considered sample
		still_next = (!have_prev_q || settle_moved) ? COUNT_WIDTH'(1) : sat_inc(still_count_q);
		move_next  = wake_moved ? sat_inc(move_count_q) : '0;
		capture    = (CMPW'(still_next) >= CMPW'(cfg.settle_votes_needed));

		take_settle = (op == OP_SAMPLE) && !have_baseline_q && due_reached && newer;
		take_wake   = (op == OP_SAMPLE) && have_baseline_q && newer;

		picked_up = take_wake && (CMPW'(move_next) >= CMPW'(cfg.wake_votes_needed));
		if (op == OP_START) begin
			armed = 1'b0;
		end else begin
			armed = have_baseline_q || (take_settle && capture);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_baseline_q   <= 1'b0;
			have_prev_q       <= 1'b0;
			last_time_valid_q <= 1'b0;
			still_count_q     <= '0;
			move_count_q      <= '0;
			sleep_start_q     <= '0;
		end else if (fire) begin
			if (op == OP_START) begin
				have_baseline_q   <= 1'b0;
				have_prev_q       <= 1'b0;
				last_time_valid_q <= 1'b0;
				still_count_q     <= '0;
				move_count_q      <= '0;
				sleep_start_q     <= time_ms;
			end else if (take_settle) begin
				last_time_valid_q <= 1'b1;
				have_prev_q       <= 1'b1;
				still_count_q     <= still_next;
				have_baseline_q   <= capture;
			end else if (take_wake) begin
				last_time_valid_q <= 1'b1;
				move_count_q      <= move_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (take_settle || take_wake)) begin
			last_time_q <= time_ms;
		end
		if (fire && take_settle) begin
			prev_x_q <= accel_x;
			prev_y_q <= accel_y;
			prev_z_q <= accel_z;
			if (capture) begin
				base_x_q <= accel_x;
				base_y_q <= accel_y;
				base_z_q <= accel_z;
			end
		end
	end

endmodule

`default_nettype wire
